// ===== rtl/remote_rw_lock_client_engine_unit_assert.svh =====
// Assertion macros used by the checker file of the lock client engine.
`ifndef REMOTE_RW_LOCK_CLIENT_ENGINE_UNIT_ASSERT_SVH
`define REMOTE_RW_LOCK_CLIENT_ENGINE_UNIT_ASSERT_SVH

// Checked at every rising edge outside reset.
`define RRLC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RRLC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rrlc_pkg.sv =====
package rrlc_pkg;

  localparam int unsigned USERS       = 64;
  localparam int unsigned OBJECT_BITS = 20;
  localparam int unsigned UIDX_W      = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int unsigned HALF_SHIFT  = 32;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOCK,
    KIND_UNLOCK,
    KIND_FADD_CPL,
    KIND_READ_CPL
  } kind_e;

  typedef enum logic [1:0] {
    PEND_IDLE,
    PEND_LOCK,
    PEND_UNLOCK,
    PEND_UNDO
  } pend_e;

  typedef enum logic [2:0] {
    ACT_FADD,
    ACT_READ,
    ACT_LOCK_RES,
    ACT_UNLOCK_RES,
    ACT_ERROR
  } action_e;

  typedef enum logic [1:0] {
    CFG_OWNER_BITS,
    CFG_TABLE_BASE,
    CFG_POLL_LIMIT,
    CFG_REPLY_BE
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [31:0] owner_bits;
    logic [63:0] table_base;
    logic [15:0] poll_limit;
    logic        big_endian;
  } cfg_t;

  typedef struct packed {
    kind_e                  kind;
    logic                   status_ok;
    logic [5:0]             user_id;
    logic                   bad_user;
    logic                   lock_mode;
    logic [OBJECT_BITS-1:0] object_index;
    logic [31:0]            sequence_number;
    logic [63:0]            value;
  } item_t;

  typedef struct packed {
    pend_e                  pend;
    logic                   htype;
    logic [OBJECT_BITS-1:0] hobj;
    logic [31:0]            hseq;
    logic [7:0]             cont;
    logic [63:0]            waiter;
    logic [15:0]            retry;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    action_e                action;
    logic [63:0]            remote_address;
    logic [63:0]            add_operand;
    logic [5:0]             user;
    logic                   ltype;
    logic [OBJECT_BITS-1:0] object_index;
    logic [31:0]            sequence_number;
    logic                   success;
    logic [7:0]             contention;
  } result_t;

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rrlc_ram.sv =====
module rrlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rrlc_front.sv =====
module rrlc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrlc_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic                             status_ok_i,
  input  logic [5:0]                       user_id_i,
  input  logic                             lock_mode_i,
  input  logic [rrlc_pkg::OBJECT_BITS-1:0] object_index_i,
  input  logic [31:0]                      sequence_number_i,
  input  logic [63:0]                      fetched_value_i,
  output logic                             q_valid_o,
  input  logic                             q_ready_i,
  output rrlc_pkg::item_t                  q_item_o
);

  rrlc_pkg::item_t                 item;
  rrlc_pkg::item_t                 entries_q [rrlc_pkg::QDEPTH];
  logic [rrlc_pkg::QPTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [rrlc_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            push, pop;

  // Fetch-add replies are put into host order here; read replies never are.
  always_comb begin
    item.kind            = rrlc_pkg::kind_e'(kind_i);
    item.status_ok       = status_ok_i;
    item.user_id         = user_id_i;
    item.bad_user        = (32'(user_id_i) >= rrlc_pkg::USERS);
    item.lock_mode       = lock_mode_i;
    item.object_index    = object_index_i;
    item.sequence_number = sequence_number_i;
    if (item.kind == rrlc_pkg::KIND_FADD_CPL && cfg_i.big_endian) begin
      item.value = rrlc_pkg::swap64(fetched_value_i);
    end else begin
      item.value = fetched_value_i;
    end
  end

  assign in_ready_o = (cnt_q != rrlc_pkg::QCNT_W'(rrlc_pkg::QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entries_q[rptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == rrlc_pkg::QPTR_W'(rrlc_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == rrlc_pkg::QPTR_W'(rrlc_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= item;
    end
  end

endmodule

// ===== rtl/rrlc_back.sv =====
module rrlc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrlc_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rrlc_pkg::item_t      q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rrlc_pkg::result_t    res_o
);

  rrlc_pkg::back_state_e         state_q, state_d;
  rrlc_pkg::item_t               cur_q;
  rrlc_pkg::result_t             res_q, res;
  rrlc_pkg::rec_t                rec, nrec;
  logic [rrlc_pkg::USERS-1:0]    vld_q;
  logic                          rec_vld_q;
  logic                          out_valid_q, out_valid_d;
  logic                          take, fire, wr, we;
  logic [rrlc_pkg::REC_W-1:0]    rdata;
  logic [15:0]                   q_uid_ext, cur_uid_ext;
  logic [rrlc_pkg::UIDX_W-1:0]   q_idx, cur_idx;

  logic                          is_req, sel_type, contend, hit_limit, free_now, clear_now;
  logic [rrlc_pkg::OBJECT_BITS-1:0] sel_obj;
  logic [63:0]                   op, neg_op, addr, rem;
  logic [7:0]                    cont_sat;

  assign q_uid_ext   = 16'(q_item_i.user_id);
  assign cur_uid_ext = 16'(cur_q.user_id);
  assign q_idx       = q_uid_ext[rrlc_pkg::UIDX_W-1:0];
  assign cur_idx     = cur_uid_ext[rrlc_pkg::UIDX_W-1:0];

  rrlc_ram #(
    .WIDTH (rrlc_pkg::REC_W),
    .DEPTH (rrlc_pkg::USERS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cur_idx),
    .wdata_i (nrec),
    .re_i    (take),
    .raddr_i (q_idx),
    .rdata_o (rdata)
  );

  assign q_ready_o = (state_q == rrlc_pkg::BK_IDLE);
  assign take      = q_ready_o & q_valid_i;
  assign fire      = (state_q == rrlc_pkg::BK_EXEC) & (~out_valid_q | out_ready_i);
  assign we        = fire & wr;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrlc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = rrlc_pkg::BK_EXEC;
        end
      end
      rrlc_pkg::BK_EXEC: begin
        if (fire) begin
          state_d = rrlc_pkg::BK_IDLE;
        end
      end
      default: state_d = rrlc_pkg::BK_IDLE;
    endcase
  end

  // A record never written reads as all zero, which is an idle user.
  always_comb begin
    rec       = rec_vld_q ? rrlc_pkg::rec_t'(rdata) : '0;
    is_req    = (cur_q.kind == rrlc_pkg::KIND_LOCK) || (cur_q.kind == rrlc_pkg::KIND_UNLOCK);
    sel_type  = is_req ? cur_q.lock_mode : rec.htype;
    sel_obj   = is_req ? cur_q.object_index : rec.hobj;
    op        = sel_type ? {cfg_i.owner_bits, 32'd0} : {32'd0, cfg_i.owner_bits};
    neg_op    = ~op + 64'd1;
    addr      = cfg_i.table_base + (64'(sel_obj) << 3);
    cont_sat  = (rec.cont != 8'hFF) ? rec.cont + 8'd1 : rec.cont;
    hit_limit = (rec.retry >= cfg_i.poll_limit);
    free_now  = rec.htype ? (cur_q.value == 64'd0)
                          : (cur_q.value[63:rrlc_pkg::HALF_SHIFT] == '0);
    rem       = rec.waiter & cur_q.value;
    clear_now = rec.htype ? (rem == 64'd0) : (rem[63:rrlc_pkg::HALF_SHIFT] == '0);

    nrec    = rec;
    wr      = 1'b0;
    contend = 1'b0;
    res.action          = rrlc_pkg::ACT_ERROR;
    res.remote_address  = '0;
    res.add_operand     = '0;
    res.success         = 1'b0;

    if (cur_q.bad_user) begin
      res.action = rrlc_pkg::ACT_ERROR;
    end else if (is_req) begin
      wr          = 1'b1;
      nrec.htype  = cur_q.lock_mode;
      nrec.hobj   = cur_q.object_index;
      nrec.hseq   = cur_q.sequence_number;
      nrec.cont   = '0;
      res.action         = rrlc_pkg::ACT_FADD;
      res.remote_address = addr;
      if (cur_q.kind == rrlc_pkg::KIND_LOCK) begin
        nrec.pend       = rrlc_pkg::PEND_LOCK;
        res.add_operand = op;
      end else begin
        nrec.pend       = rrlc_pkg::PEND_UNLOCK;
        res.add_operand = neg_op;
      end
    end else if (!cur_q.status_ok || rec.pend == rrlc_pkg::PEND_IDLE ||
                 (cur_q.kind == rrlc_pkg::KIND_READ_CPL && rec.pend != rrlc_pkg::PEND_LOCK)) begin
      res.action = rrlc_pkg::ACT_ERROR;
    end else if (cur_q.kind == rrlc_pkg::KIND_FADD_CPL) begin
      case (rec.pend)
        rrlc_pkg::PEND_LOCK: begin
          if (free_now) begin
            wr          = 1'b1;
            nrec.pend   = rrlc_pkg::PEND_IDLE;
            res.action  = rrlc_pkg::ACT_LOCK_RES;
            res.success = 1'b1;
          end else begin
            nrec.waiter = cur_q.value;
            contend     = 1'b1;
          end
        end
        rrlc_pkg::PEND_UNDO: begin
          wr         = 1'b1;
          nrec.retry = '0;
          nrec.pend  = rrlc_pkg::PEND_IDLE;
          res.action = rrlc_pkg::ACT_LOCK_RES;
        end
        default: begin
          wr          = 1'b1;
          nrec.pend   = rrlc_pkg::PEND_IDLE;
          res.action  = rrlc_pkg::ACT_UNLOCK_RES;
          res.success = 1'b1;
        end
      endcase
    end else begin
      if (clear_now) begin
        wr          = 1'b1;
        nrec.waiter = '0;
        nrec.retry  = '0;
        nrec.pend   = rrlc_pkg::PEND_IDLE;
        res.action  = rrlc_pkg::ACT_LOCK_RES;
        res.success = 1'b1;
      end else begin
        contend = 1'b1;
      end
    end

    // Contention: poll again, or back the lock out once the polls are spent.
    if (contend) begin
      wr                 = 1'b1;
      nrec.cont          = cont_sat;
      res.remote_address = addr;
      if (hit_limit) begin
        nrec.pend       = rrlc_pkg::PEND_UNDO;
        res.action      = rrlc_pkg::ACT_FADD;
        res.add_operand = neg_op;
      end else begin
        nrec.retry = rec.retry + 16'd1;
        res.action = rrlc_pkg::ACT_READ;
      end
    end

    res.user = cur_q.user_id;
    if (cur_q.bad_user) begin
      res.ltype           = 1'b0;
      res.object_index    = '0;
      res.sequence_number = '0;
      res.contention      = '0;
    end else begin
      res.ltype           = nrec.htype;
      res.object_index    = nrec.hobj;
      res.sequence_number = nrec.hseq;
      res.contention      = nrec.cont;
    end
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrlc_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        vld_q[cur_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q     <= q_item_i;
      rec_vld_q <= vld_q[q_idx];
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/remote_rw_lock_client_engine_unit.sv =====
// Remote reader-writer lock client engine.
// Input channel (in_valid_i/in_ready_o) takes one word per item: a lock or unlock
// request, or the completion of a fetch-add or read that the engine posted earlier.
// Output channel (out_valid_o/out_ready_i) gives exactly one word per input item:
// a fetch-add or read to post, a lock or unlock result, or an error.
// The configuration port writes one register per cycle while cfg_we_i is high;
// it is meant to be written while no item is in flight.
// An accepted item enters a two-word queue; the execution side reads the user's
// record and, when the output is free, puts the result into the output register.
// The execution side issues the record read in BK_IDLE and does the update and write
// back in BK_EXEC, so it takes no new item before it is through with the last.
// When the receiver stalls, the result waits in the output register, the execution
// side holds the next item, and the queue keeps accepting until it is full.
// Reset clears the queue, the output register and the per-user valid flags, so every
// user starts idle with an empty waiter mask and a zero retry count, and loads the
// registers with owner bits 1, table base 0, poll limit 16 and little-endian replies.
module remote_rw_lock_client_engine_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [63:0]                      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic                             status_ok_i,
  input  logic [5:0]                       user_id_i,
  input  logic                             lock_mode_i,
  input  logic [rrlc_pkg::OBJECT_BITS-1:0] object_index_i,
  input  logic [31:0]                      sequence_number_i,
  input  logic [63:0]                      fetched_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       action_o,
  output logic [63:0]                      remote_address_o,
  output logic [63:0]                      add_operand_o,
  output logic [5:0]                       result_user_o,
  output logic                             result_type_o,
  output logic [rrlc_pkg::OBJECT_BITS-1:0] result_object_o,
  output logic [31:0]                      result_sequence_o,
  output logic                             success_o,
  output logic [7:0]                       contention_o
);

  rrlc_pkg::cfg_t    cfg_q;
  rrlc_pkg::item_t   q_item;
  rrlc_pkg::result_t res;
  logic              q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.owner_bits <= 32'd1;
      cfg_q.table_base <= 64'd0;
      cfg_q.poll_limit <= 16'd16;
      cfg_q.big_endian <= 1'b0;
    end else if (cfg_we_i) begin
      case (rrlc_pkg::cfg_idx_e'(cfg_idx_i))
        rrlc_pkg::CFG_OWNER_BITS: cfg_q.owner_bits <= cfg_wdata_i[31:0];
        rrlc_pkg::CFG_TABLE_BASE: cfg_q.table_base <= cfg_wdata_i;
        rrlc_pkg::CFG_POLL_LIMIT: cfg_q.poll_limit <= cfg_wdata_i[15:0];
        rrlc_pkg::CFG_REPLY_BE:   cfg_q.big_endian <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  rrlc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .status_ok_i       (status_ok_i),
    .user_id_i         (user_id_i),
    .lock_mode_i       (lock_mode_i),
    .object_index_i    (object_index_i),
    .sequence_number_i (sequence_number_i),
    .fetched_value_i   (fetched_value_i),
    .q_valid_o         (q_valid),
    .q_ready_i         (q_ready),
    .q_item_o          (q_item)
  );

  rrlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign action_o          = res.action;
  assign remote_address_o  = res.remote_address;
  assign add_operand_o     = res.add_operand;
  assign result_user_o     = res.user;
  assign result_type_o     = res.ltype;
  assign result_object_o   = res.object_index;
  assign result_sequence_o = res.sequence_number;
  assign success_o         = res.success;
  assign contention_o      = res.contention;

endmodule

// ===== rtl/rrlc_checker.sv =====
`include "remote_rw_lock_client_engine_unit_assert.svh"

module rrlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  action_o,
  input logic [63:0] remote_address_o,
  input logic [63:0] add_operand_o,
  input logic        success_o
);

  `RRLC_ASSERT_ALWAYS(a_no_word_after_reset, !rst_ni |=> !out_valid_o, "output word valid after a reset cycle")

  `RRLC_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) && $stable(remote_address_o) && $stable(add_operand_o), "stalled output word changed")

  `RRLC_ASSERT(a_success_is_result, out_valid_o && success_o |-> action_o == rrlc_pkg::ACT_LOCK_RES || action_o == rrlc_pkg::ACT_UNLOCK_RES, "success flag on a word that is no result")

  `RRLC_ASSERT(a_read_no_operand, out_valid_o && action_o == rrlc_pkg::ACT_READ |-> add_operand_o == 64'd0 && !success_o, "posted read carries an operand")

  `RRLC_ASSERT(a_error_no_command, out_valid_o && action_o == rrlc_pkg::ACT_ERROR |-> remote_address_o == 64'd0 && add_operand_o == 64'd0 && !success_o, "error word carries a command")

endmodule

bind remote_rw_lock_client_engine_unit rrlc_checker u_checker (.*);

// ===== verif/rrlc_lock_checker.sv =====
`timescale 1ns / 1ps

module rrlc_lock_checker
  import rrlc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [63:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             kind_i,
  input  logic                   status_ok_i,
  input  logic [5:0]             user_id_i,
  input  logic                   lock_mode_i,
  input  logic [OBJECT_BITS-1:0] object_index_i,
  input  logic [31:0]            sequence_number_i,
  input  logic [63:0]            fetched_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [2:0]             action_i,
  input  logic [63:0]            remote_address_i,
  input  logic [63:0]            add_operand_i,
  input  logic [5:0]             result_user_i,
  input  logic                   result_type_i,
  input  logic [OBJECT_BITS-1:0] result_object_i,
  input  logic [31:0]            result_sequence_i,
  input  logic                   success_i,
  input  logic [7:0]             contention_i,
  output int                     mismatches_o,
  output int                     waiting_o
);

  logic [31:0] owner;
  logic [63:0] base;
  logic [15:0] poll_limit;
  logic        big_endian;

  pend_e                  job         [USERS];
  logic                   rec_type    [USERS];
  logic [OBJECT_BITS-1:0] rec_object  [USERS];
  logic [31:0]            rec_seq     [USERS];
  logic [7:0]             rec_cont    [USERS];
  logic [63:0]            rec_waiters [USERS];
  logic [15:0]            rec_polls   [USERS];

  result_t predicted_actions [$];

  function automatic logic [63:0] owner_operand(int u);
    return rec_type[u] ? {owner, 32'h0} : {32'h0, owner};
  endfunction

  function automatic logic [63:0] slot_addr(int u);
    return base + (64'(rec_object[u]) << 3);
  endfunction

  function automatic result_t word_for(action_e act, int u, logic [63:0] addr,
                                       logic [63:0] opnd, logic ok);
    result_t r;
    r                 = '0;
    r.action          = act;
    r.remote_address  = addr;
    r.add_operand     = opnd;
    r.user            = u[5:0];
    r.ltype           = rec_type[u];
    r.object_index    = rec_object[u];
    r.sequence_number = rec_seq[u];
    r.success         = ok;
    r.contention      = rec_cont[u];
    return r;
  endfunction

  function automatic result_t grant(int u);
    job[u] = PEND_IDLE;
    return word_for(ACT_LOCK_RES, u, '0, '0, 1'b1);
  endfunction

  // The lock is still held elsewhere: poll again, or back out once the polls are spent.
  function automatic result_t poll_or_undo(int u);
    if (rec_cont[u] != 8'hFF) rec_cont[u]++;
    if (rec_polls[u] >= poll_limit) begin
      job[u] = PEND_UNDO;
      return word_for(ACT_FADD, u, slot_addr(u), 64'(0) - owner_operand(u), 1'b0);
    end
    rec_polls[u]++;
    return word_for(ACT_READ, u, slot_addr(u), '0, 1'b0);
  endfunction

  function automatic result_t engine_response(kind_e kind, logic ok, logic [5:0] uid,
                                              logic lmode, logic [OBJECT_BITS-1:0] obj,
                                              logic [31:0] seq, logic [63:0] val);
    int          u;
    logic [63:0] word;
    logic [63:0] rem;
    logic        vacant;
    u = int'(uid);
    if (kind == KIND_LOCK || kind == KIND_UNLOCK) begin
      rec_type[u]   = lmode;
      rec_object[u] = obj;
      rec_seq[u]    = seq;
      rec_cont[u]   = '0;
      if (kind == KIND_LOCK) begin
        job[u] = PEND_LOCK;
        return word_for(ACT_FADD, u, slot_addr(u), owner_operand(u), 1'b0);
      end
      job[u] = PEND_UNLOCK;
      return word_for(ACT_FADD, u, slot_addr(u), 64'(0) - owner_operand(u), 1'b0);
    end
    if (!ok || job[u] == PEND_IDLE || (kind == KIND_READ_CPL && job[u] != PEND_LOCK)) begin
      return word_for(ACT_ERROR, u, '0, '0, 1'b0);
    end
    if (kind == KIND_FADD_CPL) begin
      word = big_endian ? swap64(val) : val;
      case (job[u])
        PEND_LOCK: begin
          vacant = rec_type[u] ? (word == '0) : (word[63:32] == '0);
          if (vacant) return grant(u);
          rec_waiters[u] = word;
          return poll_or_undo(u);
        end
        PEND_UNDO: begin
          rec_polls[u] = '0;
          job[u]       = PEND_IDLE;
          return word_for(ACT_LOCK_RES, u, '0, '0, 1'b0);
        end
        default: begin
          job[u] = PEND_IDLE;
          return word_for(ACT_UNLOCK_RES, u, '0, '0, 1'b1);
        end
      endcase
    end
    rem = rec_waiters[u] & val;
    if (rec_type[u] ? (rem == '0) : (rem[63:32] == '0)) begin
      rec_waiters[u] = '0;
      rec_polls[u]   = '0;
      return grant(u);
    end
    return poll_or_undo(u);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatches_o < 10) begin
        $display("checker: %s expected %0h got %0h", name, want, got);
      end
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      owner      = 32'd1;
      base       = '0;
      poll_limit = 16'd16;
      big_endian = 1'b0;
      for (int u = 0; u < USERS; u++) begin
        job[u]         = PEND_IDLE;
        rec_type[u]    = '0;
        rec_object[u]  = '0;
        rec_seq[u]     = '0;
        rec_cont[u]    = '0;
        rec_waiters[u] = '0;
        rec_polls[u]   = '0;
      end
      predicted_actions.delete();
      mismatches_o = 0;
      waiting_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OWNER_BITS: owner      = cfg_wdata_i[31:0];
          CFG_TABLE_BASE: base       = cfg_wdata_i;
          CFG_POLL_LIMIT: poll_limit = cfg_wdata_i[15:0];
          CFG_REPLY_BE:   big_endian = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_actions.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("checker: word for user %0d arrived with nothing predicted",
                     result_user_i);
          end
          mismatches_o++;
        end else begin
          want = predicted_actions.pop_front();
          check_field("action", 64'(want.action), 64'(action_i));
          check_field("remote_address", want.remote_address, remote_address_i);
          check_field("add_operand", want.add_operand, add_operand_i);
          check_field("result_user", 64'(want.user), 64'(result_user_i));
          check_field("result_type", 64'(want.ltype), 64'(result_type_i));
          check_field("result_object", 64'(want.object_index), 64'(result_object_i));
          check_field("result_sequence", 64'(want.sequence_number),
                      64'(result_sequence_i));
          check_field("success", 64'(want.success), 64'(success_i));
          check_field("contention", 64'(want.contention), 64'(contention_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_actions.push_back(engine_response(kind_e'(kind_i), status_ok_i, user_id_i,
                                                    lock_mode_i, object_index_i,
                                                    sequence_number_i, fetched_value_i));
      end
      waiting_o = predicted_actions.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rrlc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                   clk;
  logic                   rst_n           = 1'b0;
  logic                   cfg_we          = 1'b0;
  logic [1:0]             cfg_idx         = '0;
  logic [63:0]            cfg_wdata       = '0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic [1:0]             kind            = '0;
  logic                   status_ok       = 1'b0;
  logic [5:0]             user_id         = '0;
  logic                   lock_mode       = 1'b0;
  logic [OBJECT_BITS-1:0] object_index    = '0;
  logic [31:0]            sequence_number = '0;
  logic [63:0]            fetched_value   = '0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [2:0]             action;
  logic [63:0]            remote_address;
  logic [63:0]            add_operand;
  logic [5:0]             result_user;
  logic                   result_type;
  logic [OBJECT_BITS-1:0] result_object;
  logic [31:0]            result_sequence;
  logic                   success;
  logic [7:0]             contention;

  int mismatches;
  int waiting;

  int    in_count  = 0;
  int    out_count = 0;
  int    burst_left = 0;
  int    touched_users = 0;
  bit    touched   [USERS];
  bit    live      [USERS];
  int    post_tag  [USERS];
  int    reply_tag [USERS];
  kind_e cmd_kind  [USERS];

  remote_rw_lock_client_engine_unit i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .kind_i            (kind),
    .status_ok_i       (status_ok),
    .user_id_i         (user_id),
    .lock_mode_i       (lock_mode),
    .object_index_i    (object_index),
    .sequence_number_i (sequence_number),
    .fetched_value_i   (fetched_value),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .action_o          (action),
    .remote_address_o  (remote_address),
    .add_operand_o     (add_operand),
    .result_user_o     (result_user),
    .result_type_o     (result_type),
    .result_object_o   (result_object),
    .result_sequence_o (result_sequence),
    .success_o         (success),
    .contention_o      (contention)
  );

  rrlc_lock_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .kind_i            (kind),
    .status_ok_i       (status_ok),
    .user_id_i         (user_id),
    .lock_mode_i       (lock_mode),
    .object_index_i    (object_index),
    .sequence_number_i (sequence_number),
    .fetched_value_i   (fetched_value),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .action_i          (action),
    .remote_address_i  (remote_address),
    .add_operand_i     (add_operand),
    .result_user_i     (result_user),
    .result_type_i     (result_type),
    .result_object_i   (result_object),
    .result_sequence_i (result_sequence),
    .success_i         (success),
    .contention_i      (contention),
    .mismatches_o      (mismatches),
    .waiting_o         (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Each fetch-add or read that the engine posts is recorded here for the remote side to answer.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_count <= out_count + 1;
      case (action_e'(action))
        ACT_FADD: begin
          live[result_user]     <= 1'b1;
          post_tag[result_user] <= post_tag[result_user] + 1;
          cmd_kind[result_user] <= KIND_FADD_CPL;
        end
        ACT_READ: begin
          live[result_user]     <= 1'b1;
          post_tag[result_user] <= post_tag[result_user] + 1;
          cmd_kind[result_user] <= KIND_READ_CPL;
        end
        ACT_LOCK_RES, ACT_UNLOCK_RES: live[result_user] <= 1'b0;
        default: ;
      endcase
    end
  end

  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 1) != 0);
          3:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (span < 30) ? 1'b0 : 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic push_word(kind_e k, logic ok, logic [5:0] u, logic lt,
                           logic [OBJECT_BITS-1:0] obj, logic [31:0] sq, logic [63:0] val);
    in_valid        <= 1'b1;
    kind            <= k;
    status_ok       <= ok;
    user_id         <= u;
    lock_mode       <= lt;
    object_index    <= obj;
    sequence_number <= sq;
    fetched_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_count++;
    if ((k == KIND_LOCK || k == KIND_UNLOCK) && !touched[u]) begin
      touched[u] = 1'b1;
      touched_users++;
    end
    pace();
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] owner, logic [63:0] base, logic [15:0] limit,
                               logic be);
    write_reg(CFG_OWNER_BITS, 64'(owner));
    write_reg(CFG_TABLE_BASE, base);
    write_reg(CFG_POLL_LIMIT, 64'(limit));
    write_reg(CFG_REPLY_BE, 64'(be));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (out_count != in_count) @(posedge clk);
  endtask

  function automatic logic [63:0] sample_lock_word();
    case ($urandom_range(0, 5))
      0, 1:    return '0;
      2:       return {32'h0, $urandom()};
      3:       return {$urandom(), 32'h0};
      4:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_word();
    int                     u;
    int                     start;
    int                     pick;
    bit                     found;
    logic [OBJECT_BITS-1:0] obj;
    pick  = $urandom_range(0, 99);
    found = 1'b0;
    u     = 0;
    if (pick < 65) begin
      start = $urandom_range(0, USERS - 1);
      for (int i = 0; i < USERS && !found; i++) begin
        u = (start + i) % USERS;
        found = live[u] && (post_tag[u] != reply_tag[u]);
      end
    end
    if (found) begin
      reply_tag[u] = post_tag[u];
      push_word(cmd_kind[u], ($urandom_range(0, 15) != 0), u[5:0],
                1'($urandom_range(0, 1)), OBJECT_BITS'($urandom()), $urandom(),
                sample_lock_word());
    end else if (pick < 90 || touched_users == 0) begin
      u = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, USERS - 1);
      case ($urandom_range(0, 3))
        0:       obj = '0;
        1:       obj = '1;
        default: obj = OBJECT_BITS'($urandom());
      endcase
      push_word(($urandom_range(0, 9) < 6) ? KIND_LOCK : KIND_UNLOCK,
                1'($urandom_range(0, 1)), u[5:0], 1'($urandom_range(0, 1)), obj,
                $urandom(), {$urandom(), $urandom()});
    end else begin
      do u = $urandom_range(0, USERS - 1); while (!touched[u]);
      push_word(kind_e'($urandom_range(2, 3)), 1'($urandom_range(0, 1)), u[5:0],
                1'($urandom_range(0, 1)), OBJECT_BITS'($urandom()), $urandom(),
                {$urandom(), $urandom()});
    end
  endtask

  initial begin : stimulus
    logic [31:0] owner;
    logic [63:0] base;
    logic [15:0] limit;
    logic        be;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(32'd1, 64'h1000, 16'd1, 1'b0);
    push_word(KIND_LOCK, 1'b0, 6'd0, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd0, 1'b0, '0, 32'h0, '0);
    push_word(KIND_UNLOCK, 1'b0, 6'd0, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd0, 1'b0, '0, 32'h0, 64'h1);
    push_word(KIND_LOCK, 1'b1, 6'd1, 1'b1, '1, 32'hFFFF_FFFF, '1);
    push_word(KIND_FADD_CPL, 1'b1, 6'd1, 1'b0, '0, 32'h0, 64'h1);
    push_word(KIND_READ_CPL, 1'b1, 6'd1, 1'b0, '0, 32'h0, '1);
    push_word(KIND_FADD_CPL, 1'b1, 6'd1, 1'b0, '0, 32'h0, '1);
    push_word(KIND_LOCK, 1'b0, 6'd2, 1'b0, 20'h5_A5A5, 32'h1234_5678, '0);
    push_word(KIND_FADD_CPL, 1'b0, 6'd2, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd2, 1'b0, '0, 32'h0, 64'hFFFF_FFFF_0000_0000);
    push_word(KIND_READ_CPL, 1'b1, 6'd2, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd2, 1'b0, '0, 32'h0, '0);
    push_word(KIND_READ_CPL, 1'b1, 6'd2, 1'b0, '0, 32'h0, '0);
    push_word(KIND_UNLOCK, 1'b1, 6'd3, 1'b1, 20'hA_5A5A, 32'h8765_4321, '0);
    push_word(KIND_READ_CPL, 1'b1, 6'd3, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b0, 6'd3, 1'b0, '0, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd3, 1'b0, '0, 32'h0, '1);
    push_word(KIND_LOCK, 1'b0, 6'd63, 1'b0, '1, 32'h0, '0);
    push_word(KIND_FADD_CPL, 1'b1, 6'd63, 1'b0, '0, 32'h0, 64'h0000_0000_FFFF_FFFF);
    settle();

    for (int p = 0; p < 6; p++) begin
      owner = $urandom();
      base  = {$urandom(), $urandom()};
      case (p)
        0: begin owner = '1;            base = '1; limit = 16'd0;     be = 1'b0; end
        1: begin owner = '0;            base = '0; limit = 16'hFFFF;  be = 1'b1; end
        2: begin                                   limit = 16'd2;     be = 1'b1; end
        3: begin owner = 32'd1;         base = '0; limit = 16'd16;    be = 1'b0; end
        4: begin                                   limit = 16'd3;     be = 1'b0; end
        default: begin
          owner = 32'h8000_0000;
          limit = 16'($urandom_range(0, 5));
          be    = 1'b1;
        end
      endcase
      load_settings(owner, base, limit, be);
      repeat (67) random_word();
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
